/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is held.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/slr_pkg.sv */
// ---------------------------------------------------------------------------
// slr_pkg
// Shared constants and types of the staircase line rasterizer.
// ---------------------------------------------------------------------------
package slr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS_DEF = 32;

    // Canvas dimension registers
    localparam int DIM_BITS = 13;
    localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd4096;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CANVAS_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_CANVAS_HEIGHT = 2'd1;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Per-pixel flags from the walker to the result register
    typedef struct packed {
        logic write_pixel;
        logic last_pixel;
        logic busy_res;
    } t_pix_flags;

endpackage

/* src/staircase_line_rasterizer_top.sv */
// A step transaction's pixel is registered and shows on the output in the cycle after acceptance.
// Throughput: one transaction per cycle while o_in_stall is low; the walk-state update is the only loop.
// A start transaction loads the walk and produces no result.
// Reset (i_rst_n low, synchronous): walker idle, output empty, canvas 4096 x 4096.
// ---------------------------------------------------------------------------
// staircase_line_rasterizer_top
// Walks a line between two endpoints and emits one pixel per step command.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module staircase_line_rasterizer_top
    import slr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [DIM_BITS-1:0]   i_cfg_data,
    // Command channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_line_color,
    // Pixel channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_write_pixel,
    output logic                  o_last_pixel,
    output logic                  o_busy_res
);

    logic [DIM_BITS-1:0] r_canvas_width;
    logic [DIM_BITS-1:0] r_canvas_height;

    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y;
    logic [COLOR_BITS-1:0] r_pixel_color;
    t_pix_flags            r_flags;

    logic                  in_take;
    logic                  load_result;
    logic [COORD_BITS-1:0] walk_x;
    logic [COORD_BITS-1:0] walk_y;
    logic [COLOR_BITS-1:0] walk_color;
    t_pix_flags            walk_flags;

    // Canvas size registers; unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= DIM_RESET;
            r_canvas_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input only while a finished pixel is stuck at a stalled output;
    // a pixel leaving this cycle frees the register for the next one.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;
    assign load_result = in_take && (i_cmd == CMD_STEP);

    slr_walk #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (in_take),
        .i_cmd           (i_cmd),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_line_color    (i_line_color),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .o_pixel_x       (walk_x),
        .o_pixel_y       (walk_y),
        .o_pixel_color   (walk_color),
        .o_flags         (walk_flags)
    );

    // Output valid: set by a step transaction, cleared once taken, held under stall.
    always_comb begin
        priority if (load_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the current pixel of the walk before the walker advances.
    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_pixel_x     <= walk_x;
            r_pixel_y     <= walk_y;
            r_pixel_color <= walk_color;
            r_flags       <= walk_flags;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_pixel_color = r_pixel_color;
    assign o_write_pixel = r_flags.write_pixel;
    assign o_last_pixel  = r_flags.last_pixel;
    assign o_busy_res    = r_flags.busy_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `ASSERT_AT(a_stalled_pixel_kept, i_clk, i_rst_n, r_out_valid && i_out_stall |=> r_out_valid, "stalled pixel dropped")
    `ASSERT_AT(a_last_not_busy, i_clk, i_rst_n, o_out_valid |-> !(o_last_pixel && o_busy_res), "last and busy together")
    `ASSERT_AT(a_write_needs_line, i_clk, i_rst_n, o_out_valid && o_write_pixel |-> (o_last_pixel || o_busy_res), "pixel written while idle")

endmodule

/* src/slr_walk.sv */
// ---------------------------------------------------------------------------
// slr_walk
// Line walk state: loads endpoints on start, advances one pixel per step.
// ---------------------------------------------------------------------------
module slr_walk
    import slr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_cmd,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_line_color,
    input  logic [DIM_BITS-1:0]   i_canvas_width,
    input  logic [DIM_BITS-1:0]   i_canvas_height,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output t_pix_flags            o_flags
);

    localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic                  r_active,   n_active;
    logic                  r_x_back,   n_x_back;
    logic [COORD_BITS-1:0] r_cur_x,    n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y,    n_cur_y;
    logic [COORD_BITS-1:0] r_left_dx,  n_left_dx;
    logic [COORD_BITS-1:0] r_left_dy,  n_left_dy;
    logic [COLOR_BITS-1:0] r_color,    n_color;

    logic x_lt, y_lt, y_eq, last, in_canvas;
    logic [COORD_BITS-1:0] load_dx, load_dy;

    assign x_lt    = i_start_x < i_end_x;
    assign y_lt    = i_start_y < i_end_y;
    assign y_eq    = i_start_y == i_end_y;
    assign load_dx = x_lt ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign load_dy = y_lt ? (i_end_y - i_start_y) : (i_start_y - i_end_y);

    assign last      = (r_left_dx == '0) && (r_left_dy == '0);
    assign in_canvas = (CMP_BITS'(r_cur_x) < CMP_BITS'(i_canvas_width)) &&
                       (CMP_BITS'(r_cur_y) < CMP_BITS'(i_canvas_height));

    always_comb begin
        n_active  = r_active;
        n_x_back  = r_x_back;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_left_dx = r_left_dx;
        n_left_dy = r_left_dy;
        n_color   = r_color;
        if (i_take && (i_cmd == CMD_START)) begin
            // Walk always starts at the lower y; a flat line starts at the lower x.
            n_active  = 1'b1;
            n_color   = i_line_color;
            n_left_dx = load_dx;
            n_left_dy = load_dy;
            n_cur_y   = y_lt ? i_start_y : i_end_y;
            if (y_eq) begin
                n_cur_x  = x_lt ? i_start_x : i_end_x;
                n_x_back = 1'b0;
            end else if (y_lt) begin
                n_cur_x  = i_start_x;
                n_x_back = i_end_x < i_start_x;
            end else begin
                n_cur_x  = i_end_x;
                n_x_back = x_lt;
            end
        end else if (i_take && r_active) begin
            priority if (last) begin
                n_active = 1'b0;
            end else if (r_left_dx > r_left_dy) begin
                n_left_dx = r_left_dx - ONE;
                n_cur_x   = r_x_back ? (r_cur_x - ONE) : (r_cur_x + ONE);
            end else begin
                n_left_dy = r_left_dy - ONE;
                n_cur_y   = r_cur_y + ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_back  <= n_x_back;
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_left_dx <= n_left_dx;
        r_left_dy <= n_left_dy;
        r_color   <= n_color;
    end

    // An idle walker reports an all-zero pixel.
    assign o_pixel_x           = r_active ? r_cur_x : '0;
    assign o_pixel_y           = r_active ? r_cur_y : '0;
    assign o_pixel_color       = r_active ? r_color : '0;
    assign o_flags.write_pixel = r_active && in_canvas;
    assign o_flags.last_pixel  = r_active && last;
    assign o_flags.busy_res    = r_active && !last;

endmodule

/* tb/tb_staircase_line_rasterizer_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_staircase_line_rasterizer_top
// Self-checking bench for the staircase line rasterizer. A directed table
// covers single-pixel lines, idle steps, coordinate extremes and mid-walk
// restarts. Random line sequences follow under several canvas settings and
// idle patterns. Every pixel transaction is compared against a cycle-free
// walk predictor kept inside the bench.
// ---------------------------------------------------------------------------
module tb_staircase_line_rasterizer_top;
    import slr_pkg::*;

    localparam int COORD_W     = COORD_BITS_DEF;
    localparam int COLOR_W     = COLOR_BITS_DEF;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int STALL_LIMIT = 3000;   // cycles without any transaction
    localparam int DRAIN_WAIT  = 4;      // output register delay plus margin
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int PHASE_ITEMS = 300;

    // Register indexes the block does not decode
    localparam t_cfg_idx CFG_SPARE_LO = 2'd2;
    localparam t_cfg_idx CFG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        WALK_VERTICAL   = 2'd0,
        WALK_HORIZONTAL = 2'd1,
        WALK_STAIR      = 2'd2
    } walk_mode_e;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               wr;
        logic               last;
        logic               busy;
    } pixel_t;

    typedef struct {
        logic               cmd;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COLOR_W-1:0] color;
        bit                 typed;   // use 'want' instead of the predictor
        pixel_t             want;
    } cmd_item_t;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_CANVAS_WIDTH;
    logic [DIM_BITS-1:0]   i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = CMD_START;
    logic [COORD_W-1:0]    i_start_x = '0;
    logic [COORD_W-1:0]    i_start_y = '0;
    logic [COORD_W-1:0]    i_end_x = '0;
    logic [COORD_W-1:0]    i_end_y = '0;
    logic [COLOR_W-1:0]    i_line_color = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COORD_W-1:0]    o_pixel_x;
    logic [COORD_W-1:0]    o_pixel_y;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_write_pixel;
    logic                  o_last_pixel;
    logic                  o_busy_res;

    // Predictor state: canvas registers and the walk in progress
    logic [DIM_BITS-1:0]   canvas_w = DIM_RESET;
    logic [DIM_BITS-1:0]   canvas_h = DIM_RESET;
    bit                    walk_on = 1'b0;
    walk_mode_e            walk_mode = WALK_VERTICAL;
    bit                    walk_back = 1'b0;
    logic [COORD_W-1:0]    pos_x = '0;
    logic [COORD_W-1:0]    pos_y = '0;
    logic [DIM_BITS-1:0]   rem_dx = '0;
    logic [DIM_BITS-1:0]   rem_dy = '0;
    logic [COLOR_W-1:0]    line_rgb = '0;

    pixel_t                pixels_due[$];
    cmd_item_t             cur_item;
    int                    fails = 0;
    int                    stuck_cycles = 0;
    int                    send_gap_pct = 0;
    int                    recv_gap_pct = 0;
    bit                    hold_req = 1'b0;
    int                    hold_left = 0;

    staircase_line_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_line_color  (i_line_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_write_pixel (o_write_pixel),
        .o_last_pixel  (o_last_pixel),
        .o_busy_res    (o_busy_res)
    );

    always #1 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Load a new line; the walk starts at the lower end (smaller y), or at
    // the smaller x / smaller y for axis-aligned runs.
    function automatic void load_walk(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                      input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        walk_back = 1'b0;
        if (sx == ex) begin
            walk_mode = WALK_VERTICAL;
            pos_x     = sx;
            pos_y     = (sy < ey) ? sy : ey;
            rem_dx    = '0;
            rem_dy    = (sy < ey) ? DIM_BITS'(ey - sy) : DIM_BITS'(sy - ey);
        end else if (sy == ey) begin
            walk_mode = WALK_HORIZONTAL;
            pos_x     = (sx < ex) ? sx : ex;
            pos_y     = sy;
            rem_dx    = (sx < ex) ? DIM_BITS'(ex - sx) : DIM_BITS'(sx - ex);
            rem_dy    = '0;
        end else begin
            walk_mode = WALK_STAIR;
            if (sy < ey) begin
                pos_x     = sx;
                pos_y     = sy;
                walk_back = (ex < sx);
            end else begin
                pos_x     = ex;
                pos_y     = ey;
                walk_back = (sx < ex);
            end
            rem_dx = (sx < ex) ? DIM_BITS'(ex - sx) : DIM_BITS'(sx - ex);
            rem_dy = (sy < ey) ? DIM_BITS'(ey - sy) : DIM_BITS'(sy - ey);
        end
        walk_on = 1'b1;
    endfunction

    // Emit the current pixel and advance the walk by one move.
    function automatic pixel_t next_pixel();
        pixel_t p;
        bit     fin;
        p = '{default: '0};
        if (!walk_on) return p;
        fin     = (rem_dx == 0) && (rem_dy == 0);
        p.x     = pos_x;
        p.y     = pos_y;
        p.color = line_rgb;
        p.wr    = ({1'b0, pos_x} < canvas_w) && ({1'b0, pos_y} < canvas_h);
        p.last  = fin;
        p.busy  = !fin;
        if (fin) begin
            walk_on = 1'b0;
        end else if (rem_dx > rem_dy) begin
            rem_dx = rem_dx - 1'b1;
            pos_x  = walk_back ? pos_x - 1'b1 : pos_x + 1'b1;
        end else begin
            rem_dy = rem_dy - 1'b1;
            pos_y  = pos_y + 1'b1;
        end
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Monitor: sample both channels and the config port at the rising edge
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        pixel_t want;
        pixel_t pix;
        bit     moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            stuck_cycles = 0;
        end else begin
            // Mirror register writes; undecoded indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CANVAS_WIDTH:  canvas_w = i_cfg_data;
                    CFG_CANVAS_HEIGHT: canvas_h = i_cfg_data;
                    default: ;
                endcase
            end
            // Command transaction: start loads the walk, step owes one pixel
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                if (i_cmd == CMD_START) begin
                    load_walk(i_start_x, i_start_y, i_end_x, i_end_y);
                    line_rgb = i_line_color;
                end else begin
                    pix = next_pixel();
                    pixels_due.push_back(cur_item.typed ? cur_item.want : pix);
                end
            end
            // Pixel transaction: match against the oldest owed pixel
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pixels_due.size() == 0) begin
                    $error("pixel transaction with nothing expected (x %0h y %0h)",
                           o_pixel_x, o_pixel_y);
                    fails++;
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", want.x, o_pixel_x);
                    check_field("pixel_y", want.y, o_pixel_y);
                    check_field("pixel_color", want.color, o_pixel_color);
                    check_field("write_pixel", want.wr, o_write_pixel);
                    check_field("last_pixel", want.last, o_last_pixel);
                    check_field("busy_res", want.busy, o_busy_res);
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin
        while (stuck_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("** staircase_line_rasterizer_top: FAILED **");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall at the falling edge, plus a long counted hold
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < recv_gap_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Step transaction; the endpoint and color fields carry junk to prove
    // they are ignored.
    function automatic cmd_item_t step_item();
        cmd_item_t it;
        it.cmd   = CMD_STEP;
        it.sx    = COORD_W'($urandom());
        it.sy    = COORD_W'($urandom());
        it.ex    = COORD_W'($urandom());
        it.ey    = COORD_W'($urandom());
        it.color = $urandom();
        it.typed = 1'b0;
        it.want  = '{default: '0};
        return it;
    endfunction

    function automatic cmd_item_t start_item(input int sx, input int sy, input int ex,
                                             input int ey, input logic [COLOR_W-1:0] color);
        cmd_item_t it;
        it.cmd   = CMD_START;
        it.sx    = COORD_W'(sx);
        it.sy    = COORD_W'(sy);
        it.ex    = COORD_W'(ex);
        it.ey    = COORD_W'(ey);
        it.color = color;
        it.typed = 1'b0;
        it.want  = '{default: '0};
        return it;
    endfunction

    function automatic cmd_item_t typed_step(input int x, input int y,
                                             input logic [COLOR_W-1:0] color,
                                             input bit wr, input bit last, input bit busy);
        cmd_item_t it;
        it            = step_item();
        it.typed      = 1'b1;
        it.want.x     = COORD_W'(x);
        it.want.y     = COORD_W'(y);
        it.want.color = color;
        it.want.wr    = wr;
        it.want.last  = last;
        it.want.busy  = busy;
        return it;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Bias coordinates toward the canvas edge and the field extremes
    function automatic int pick_coord(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, COORD_MAX);
        if (r < 8) return clamp_coord(lim - 8 + $urandom_range(0, 16));
        if (r == 8) return $urandom_range(0, 7);
        return COORD_MAX - $urandom_range(0, 7);
    endfunction

    // Offer one command transaction; hold payload until accepted
    task automatic send(input cmd_item_t it);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        cur_item     = it;
        i_cmd        = it.cmd;
        i_start_x    = it.sx;
        i_start_y    = it.sy;
        i_end_x      = it.ex;
        i_end_y      = it.ey;
        i_line_color = it.color;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain all owed pixels, then let a trailing start transaction land
    task automatic settle();
        i_in_valid = 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [DIM_BITS-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Mostly complete lines with random content; some truncated walks that
    // get restarted, stray steps, and over-stepping past the last pixel.
    task automatic run_phase(input int w, input int h, input int snd_pct, input int rcv_pct,
                             input bit pressure);
        int sent;
        int kind;
        int shape;
        int sx, sy, ex, ey;
        int span;
        int pixels;
        int steps;
        bit held;
        settle();
        write_cfg(CFG_CANVAS_WIDTH, DIM_BITS'(w));
        write_cfg(CFG_CANVAS_HEIGHT, DIM_BITS'(h));
        send_gap_pct = snd_pct;
        recv_gap_pct = rcv_pct;
        sent = 0;
        held = 1'b0;
        while (sent < PHASE_ITEMS) begin
            // Hold the receiver off midway while commands keep coming
            if (pressure && !held && sent >= PHASE_ITEMS / 2) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send(step_item());
                sent++;
            end else begin
                sx   = pick_coord(int'(canvas_w));
                sy   = pick_coord(int'(canvas_h));
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 200)
                                                    : $urandom_range(1, 12);
                ex   = clamp_coord($urandom_range(0, 1) ? sx + span : sx - span);
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 200)
                                                    : $urandom_range(1, 12);
                ey   = clamp_coord($urandom_range(0, 1) ? sy + span : sy - span);
                shape = $urandom_range(0, 9);
                if (shape < 2) begin
                    ex = sx;
                end else if (shape < 4) begin
                    ey = sy;
                end else if (shape == 4) begin
                    ex = sx;
                    ey = sy;
                end
                send(start_item(sx, sy, ex, ey, $urandom()));
                sent++;
                pixels = ((ex > sx) ? ex - sx : sx - ex) + ((ey > sy) ? ey - sy : sy - ey) + 1;
                if (kind < 16) begin
                    steps = $urandom_range(0, pixels);
                end else begin
                    steps = pixels + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                end
                repeat (steps) begin
                    send(step_item());
                    sent++;
                end
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        cmd_item_t directed[$];
        cur_item = step_item();

        // Hold reset at the start, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Writes to undecoded indexes must leave the canvas untouched
        write_cfg(CFG_SPARE_LO, '0);
        write_cfg(CFG_SPARE_HI, '1);

        // Step before any line: all-zero pixel
        directed.push_back(typed_step(0, 0, '0, 0, 0, 0));
        // Degenerate line at the origin, then a step past its end
        directed.push_back(start_item(0, 0, 0, 0, '1));
        directed.push_back(typed_step(0, 0, '1, 1, 1, 0));
        directed.push_back(typed_step(0, 0, '0, 0, 0, 0));
        // Degenerate line at the far corner
        directed.push_back(start_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '0));
        directed.push_back(typed_step(COORD_MAX, COORD_MAX, '0, 1, 1, 0));
        // Vertical run given top-down; left unfinished, then restarted
        directed.push_back(start_item(5, 9, 5, 6, 32'hA5A5_A5A5));
        repeat (3) directed.push_back(step_item());
        // Horizontal run given right-to-left at the x extreme
        directed.push_back(start_item(COORD_MAX, 3, COORD_MAX - 3, 3, 32'h5A5A_5A5A));
        repeat (4) directed.push_back(step_item());
        // Backward staircase, cut short by a restart
        directed.push_back(start_item(COORD_MAX, 0, COORD_MAX - 3, 1, 32'h0F0F_0F0F));
        repeat (2) directed.push_back(step_item());
        // Staircase given from the higher-y end; walk starts at the second point
        directed.push_back(start_item(0, COORD_MAX, 2, COORD_MAX - 2, 32'hF0F0_F0F0));
        repeat (6) directed.push_back(step_item());

        foreach (directed[i]) send(directed[i]);

        // Random phases: canvas extremes and idle patterns
        run_phase(4096, 4096, 28, 47, 1'b1);
        run_phase(0, 8191, 28, 47, 1'b0);
        run_phase(8191, 1, 47, 28, 1'b0);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 47, 28, 1'b0);
        run_phase(1, 4096, 0, 0, 1'b0);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 0, 0, 1'b0);

        settle();
        repeat (20) @(negedge i_clk);
        if (pixels_due.size() != 0) begin
            $error("%0d expected pixels never arrived", pixels_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("** staircase_line_rasterizer_top: PASSED **");
        end else begin
            $display("** staircase_line_rasterizer_top: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/slr_pkg.sv
src/slr_walk.sv
src/staircase_line_rasterizer_top.sv
tb/tb_staircase_line_rasterizer_top.sv
